>>> rtl/multi_entry_timeout_table_unit_assert.svh
// Assertion macros shared by the timeout table modules.
`ifndef MULTI_ENTRY_TIMEOUT_TABLE_UNIT_ASSERT_SVH
`define MULTI_ENTRY_TIMEOUT_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define METT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timeout table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define METT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timeout table assertion failed");

`endif

>>> rtl/mett_pkg.sv
// Types and constants shared by the timeout table modules.
`timescale 1ns / 1ps
package mett_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd30000;
    localparam logic [15:0] SCAN_INTERVAL_RST   = 16'd500;

    typedef enum logic [1:0] {
        OP_WATCH    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_TICK     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_TIMEOUT = 2'd0,
        CFG_SCAN_INTERVAL   = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        EV_EXPIRED  = 1'b0,
        EV_REJECTED = 1'b1
    } t_ev;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] seq_number;
        logic [31:0] timeout_ms;
        logic        use_default;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_seq;
        logic        event_kind;
        logic        last;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic cap;
        logic rd;
        logic chk_watch;
        logic chk_done;
        logic take;
        logic wr;
        logic rej;
        logic flush;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic tick_scan;
        logic expired;
        logic pend_v;
        logic out_free;
        logic can_store;
    } t_st;

endpackage

>>> rtl/mett_ctrl.sv
// Sequencer that walks the slot table for watch, complete and scan words.
`timescale 1ns / 1ps
`include "multi_entry_timeout_table_unit_assert.svh"
module mett_ctrl import mett_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    output logic             o_in_ready,
    input  t_st              i_st,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_APPLY,
        S_FLUSH
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [RES_CNT_W-1:0]   r_nres, n_nres;
    t_cmd                   cmd;
    logic                   at_last;

    assign at_last    = (r_idx == LAST_IDX);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
    assign o_idx      = r_idx;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_idx   = r_idx;
        n_nres  = r_nres;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_op    = t_op'(i_opcode);
                    n_idx   = '0;
                    n_nres  = '0;
                    case (t_op'(i_opcode))
                        OP_WATCH:    n_state = S_RD;
                        OP_COMPLETE: n_state = S_RD;
                        OP_TICK:     n_state = i_st.tick_scan ? S_RD : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                case (r_op)
                    OP_WATCH: begin
                        cmd.chk_watch = 1'b1;
                        n_state = at_last ? S_APPLY : S_RD;
                        n_idx   = r_idx + IDX_W'(1);
                    end
                    OP_COMPLETE: begin
                        cmd.chk_done = 1'b1;
                        n_state = at_last ? S_IDLE : S_RD;
                        n_idx   = r_idx + IDX_W'(1);
                    end
                    OP_TICK: begin
                        if (i_st.expired) begin
                            // The held word can only move on once the output stage has room.
                            if (!i_st.pend_v || i_st.out_free) begin
                                cmd.take = 1'b1;
                                n_nres   = r_nres + RES_CNT_W'(1);
                                n_idx    = r_idx + IDX_W'(1);
                                if (at_last || (r_nres == RES_CNT_W'(MAX_RESULTS - 1))) begin
                                    n_state = S_FLUSH;
                                end else begin
                                    n_state = S_RD;
                                end
                            end
                        end else begin
                            n_state = at_last ? S_FLUSH : S_RD;
                            n_idx   = r_idx + IDX_W'(1);
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_APPLY: begin
                if (i_st.can_store) begin
                    cmd.wr  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    cmd.rej = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!i_st.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    cmd.flush = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_idx   <= '0;
            r_nres  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
            r_nres  <= n_nres;
        end
    end

    `METT_ASSERT_IMP(a_take_in_scan, cmd.take, (r_state == S_CHK) && (r_op == OP_TICK))
    `METT_ASSERT_IMP(a_res_bound, 1'b1, r_nres <= RES_CNT_W'(MAX_RESULTS))
    `METT_ASSERT_NXT(a_scan_start, cmd.cap && (i_opcode == OP_TICK) && i_st.tick_scan, r_state == S_RD)

endmodule

>>> rtl/mett_dp.sv
// Slot storage, time keeping, configuration and output staging.
`timescale 1ns / 1ps
`include "multi_entry_timeout_table_unit_assert.svh"
module mett_dp import mett_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    input  logic [IDX_W-1:0]      i_idx,
    output t_st                   o_st,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out
);

    logic [31:0]        r_dflt;
    logic [15:0]        r_intv;
    logic [TIME_W-1:0]  r_now;
    logic [15:0]        r_cnt;
    logic [ENTRIES-1:0] r_valid;
    t_in_word           r_in;

    logic [31:0]        r_mem_seq [ENTRIES];
    logic [TIME_W-1:0]  r_mem_dl  [ENTRIES];
    logic [31:0]        r_rd_seq;
    logic [TIME_W-1:0]  r_rd_dl;

    logic               r_hit, r_free;
    logic [IDX_W-1:0]   r_hit_idx, r_free_idx;
    logic               r_pend_v;
    logic [31:0]        r_pend_seq;
    logic               r_out_v;
    t_out_word          r_out;

    logic [15:0]        intv_eff;
    logic [15:0]        cnt_inc;
    logic [TIME_W-1:0]  now_inc;
    logic [31:0]        tmo;
    logic [TIME_W:0]    dl_sum;
    logic [TIME_W-1:0]  dl;
    logic               slot_v;
    logic               seq_eq;
    logic               out_free;
    logic [IDX_W-1:0]   wr_idx;
    logic               push_pend;

    assign intv_eff  = (r_intv == 16'd0) ? 16'd1 : r_intv;
    assign cnt_inc   = r_cnt + 16'd1;
    assign now_inc   = (r_now == TIME_MAX) ? r_now : r_now + TIME_W'(1);
    assign tmo       = r_in.use_default ? r_dflt : r_in.timeout_ms;
    assign dl_sum    = {1'b0, r_now} + (TIME_W + 1)'(tmo);
    assign dl        = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
    assign slot_v    = r_valid[i_idx];
    assign seq_eq    = (r_rd_seq == r_in.seq_number);
    assign out_free  = !r_out_v || i_out_ready;
    assign wr_idx    = r_hit ? r_hit_idx : r_free_idx;
    assign push_pend = i_cmd.take && r_pend_v;

    assign o_st.tick_scan = (cnt_inc >= intv_eff);
    assign o_st.expired   = slot_v && (r_now >= r_rd_dl);
    assign o_st.pend_v    = r_pend_v;
    assign o_st.out_free  = out_free;
    assign o_st.can_store = r_hit || r_free;

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= DEFAULT_TIMEOUT_RST;
            r_intv <= SCAN_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEFAULT_TIMEOUT: r_dflt <= i_cfg_data[31:0];
                CFG_SCAN_INTERVAL:   r_intv <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                if (i_in.opcode == OP_TICK) begin
                    r_now <= now_inc;
                    r_cnt <= o_st.tick_scan ? 16'd0 : cnt_inc;
                end
            end
            // The first match and the lowest free slot win during the sweep.
            if (i_cmd.chk_watch) begin
                if (slot_v && seq_eq && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!slot_v && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.chk_done && slot_v && seq_eq) begin
                r_valid[i_idx] <= 1'b0;
            end
            if (i_cmd.take) begin
                r_valid[i_idx] <= 1'b0;
                r_pend_v       <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.wr) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (push_pend || i_cmd.rej || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_in <= i_in;
        end
        if (i_cmd.chk_watch && slot_v && seq_eq && !r_hit) begin
            r_hit_idx <= i_idx;
        end
        if (i_cmd.chk_watch && !slot_v && !r_free) begin
            r_free_idx <= i_idx;
        end
        if (i_cmd.take) begin
            r_pend_seq <= r_rd_seq;
        end
        // A scan result is held back until the next expiry or the end of the scan so that its last flag is known.
        if (push_pend) begin
            r_out.out_seq    <= r_pend_seq;
            r_out.event_kind <= EV_EXPIRED;
            r_out.last       <= 1'b0;
        end else if (i_cmd.rej) begin
            r_out.out_seq    <= r_in.seq_number;
            r_out.event_kind <= EV_REJECTED;
            r_out.last       <= 1'b1;
        end else if (i_cmd.flush) begin
            r_out.out_seq    <= r_pend_seq;
            r_out.event_kind <= EV_EXPIRED;
            r_out.last       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem_seq[wr_idx] <= r_in.seq_number;
            r_mem_dl[wr_idx]  <= dl;
        end
        if (i_cmd.rd) begin
            r_rd_seq <= r_mem_seq[i_idx];
            r_rd_dl  <= r_mem_dl[i_idx];
        end
    end

    `METT_ASSERT_IMP(a_push_room, push_pend, out_free)
    `METT_ASSERT_NXT(a_flush_empties, i_cmd.flush, !r_pend_v && r_out_v)
    `METT_ASSERT_IMP(a_store_slot, i_cmd.wr, r_hit || r_free)

endmodule

>>> rtl/multi_entry_timeout_table_unit.sv
// Top level of the multi-entry deadline watchdog table.
//
// Input words arrive on a valid/ready channel: watch (store a sequence number
// with a deadline), complete (remove it) and tick (one millisecond of time).
// Result words leave on a valid/ready channel: an expiry or a rejected watch,
// with last marking the final word caused by one input word.
// Configuration is a plain write port: write enable, register index, data.
// A tick that does not start a scan only advances the time and the tick count.
// Watch, complete and a scanning tick sweep the slot memory one slot at a time
// through its single registered read port; a scan also ends once MAX_RESULTS
// expiries are taken. A watch or a scan may wait for the output stage.
// The output register decouples the sides: a new word is accepted while a
// result still waits. When the receiver stalls, a scan holds at an expired
// slot while a result is held back, until the output stage frees.
// Reset clears all valid bits, the time and the tick count and sets the registers
// to their defaults; slot contents are left as they are.
`timescale 1ns / 1ps
module multi_entry_timeout_table_unit import mett_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cmd             cmd;
    t_st              st;
    logic [IDX_W-1:0] idx;

    mett_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    mett_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
